// File: rtl/core/ekdq_pkg.sv
package ekdq_pkg;

   localparam int QueueDepth = 16;
   localparam int KeyWidth   = 9;

   typedef logic [KeyWidth-1:0] key_type;
   typedef logic [7:0]          char_type;

   localparam char_type CharEsc      = 8'h1B;
   localparam char_type CharLBracket = 8'h5B;
   localparam char_type CharTilde    = 8'h7E;
   localparam char_type CharA        = 8'h41;
   localparam char_type CharB        = 8'h42;
   localparam char_type CharC        = 8'h43;
   localparam char_type CharD        = 8'h44;
   localparam char_type CharH        = 8'h48;
   localparam char_type CharF        = 8'h46;
   localparam char_type CharZero     = 8'h30;
   localparam char_type CharThree    = 8'h33;
   localparam char_type CharFive     = 8'h35;
   localparam char_type CharSix      = 8'h36;
   localparam char_type CharNine     = 8'h39;

   localparam key_type KeyUnknown = 9'd256;
   localparam key_type KeyEsc     = 9'd257;
   localparam key_type KeyUp      = 9'd258;
   localparam key_type KeyDown    = 9'd259;
   localparam key_type KeyRight   = 9'd260;
   localparam key_type KeyLeft    = 9'd261;
   localparam key_type KeyHome    = 9'd262;
   localparam key_type KeyEnd     = 9'd263;
   localparam key_type KeyDelete  = 9'd264;
   localparam key_type KeyPgUp    = 9'd265;
   localparam key_type KeyPgDn    = 9'd266;

   // event produced by the parser
   typedef struct packed {
      logic    valid;
      key_type code;
   } push_type;

   // broadcast to every queue cell
   typedef struct packed {
      logic    pop;
      logic    push;
      key_type code;
   } cell_ctrl_type;

   // contents of one queue cell
   typedef struct packed {
      logic    valid;
      key_type code;
   } cell_state_type;

   function automatic key_type letter_key(input char_type b);
      key_type k;
      case (b)
         CharA:   k = KeyUp;
         CharB:   k = KeyDown;
         CharC:   k = KeyRight;
         CharD:   k = KeyLeft;
         CharH:   k = KeyHome;
         CharF:   k = KeyEnd;
         default: k = KeyUnknown;
      endcase
      return k;
   endfunction

   function automatic key_type tilde_key(input char_type digit);
      key_type k;
      case (digit)
         CharThree: k = KeyDelete;
         CharFive:  k = KeyPgUp;
         CharSix:   k = KeyPgDn;
         default:   k = KeyUnknown;
      endcase
      return k;
   endfunction

endpackage

// File: rtl/core/ekdq_parser.sv
module ekdq_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               byte_beat,
   input  ekdq_pkg::char_type in_byte,
   output ekdq_pkg::push_type push
);

   localparam logic [1:0] PhIdle   = 2'd0;
   localparam logic [1:0] PhFirst  = 2'd1;
   localparam logic [1:0] PhSecond = 2'd2;
   localparam logic [1:0] PhThird  = 2'd3;

   logic [1:0]         phase_ff, phase_in;
   logic               bracket_ff, bracket_in;
   ekdq_pkg::char_type digit_ff, digit_in;

   always_comb begin
      phase_in   = phase_ff;
      bracket_in = bracket_ff;
      digit_in   = digit_ff;
      push.valid = 1'b0;
      push.code  = {1'b0, in_byte};
      if (byte_beat) begin
         case (phase_ff)
            PhIdle: begin
               if (in_byte == ekdq_pkg::CharEsc) begin
                  phase_in = PhFirst;
               end else begin
                  push.valid = 1'b1;
               end
            end
            PhFirst: begin
               bracket_in = (in_byte == ekdq_pkg::CharLBracket);
               phase_in   = PhSecond;
            end
            PhSecond: begin
               if (!bracket_ff) begin
                  push.valid = 1'b1;
                  push.code  = ekdq_pkg::KeyEsc;
                  phase_in   = PhIdle;
               end else if (in_byte inside {[ekdq_pkg::CharZero:ekdq_pkg::CharNine]}) begin
                  digit_in = in_byte;
                  phase_in = PhThird;
               end else begin
                  push.valid = 1'b1;
                  push.code  = ekdq_pkg::letter_key(in_byte);
                  phase_in   = PhIdle;
               end
            end
            default: begin
               push.valid = 1'b1;
               push.code  = (in_byte == ekdq_pkg::CharTilde) ?
                            ekdq_pkg::tilde_key(digit_ff) : ekdq_pkg::KeyUnknown;
               phase_in   = PhIdle;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PhIdle;
         bracket_ff <= 1'b0;
         digit_ff   <= '0;
      end else begin
         phase_ff   <= phase_in;
         bracket_ff <= bracket_in;
         digit_ff   <= digit_in;
      end
   end

endmodule

// File: rtl/core/ekdq_cell.sv
module ekdq_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  ekdq_pkg::cell_ctrl_type  ctrl,
   input  logic                     prev_valid,
   input  ekdq_pkg::cell_state_type next_cell,
   output ekdq_pkg::cell_state_type contents
);

   logic              valid_ff, valid_in;
   ekdq_pkg::key_type code_ff, code_in;

   // pop shifts toward the head; push fills the first empty cell
   always_comb begin
      valid_in = valid_ff;
      code_in  = code_ff;
      if (ctrl.pop) begin
         valid_in = next_cell.valid;
         code_in  = next_cell.code;
      end else if (ctrl.push && !valid_ff && prev_valid) begin
         valid_in = 1'b1;
         code_in  = ctrl.code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
   end

   assign contents.valid = valid_ff;
   assign contents.code  = code_ff;

endmodule

// File: rtl/core/escape_key_decoder_queue_top.sv
// Byte beats: decoded combinationally when accepted; any event is registered into the first empty cell.
// Pop beats: result valid in the cycle after acceptance, from the head cell.
// Throughput: one beat per cycle; a pop stalls only while a result waits.
// Queue is a row of QUEUE_DEPTH cells that shift toward the head on a pop.
// Reset (synchronous, active high) empties the queue and idles the parser.
module escape_key_decoder_queue_top #(
   parameter int QUEUE_DEPTH = ekdq_pkg::QueueDepth
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_opcode,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [8:0] rsp_keycode,
   output logic       rsp_queue_was_empty
);

   logic                     accept, byte_beat, pop_beat;
   ekdq_pkg::push_type       push;
   ekdq_pkg::cell_ctrl_type  ctrl;
   ekdq_pkg::cell_state_type cells [QUEUE_DEPTH];

   logic              rsp_valid_ff, rsp_valid_in;
   ekdq_pkg::key_type rsp_keycode_ff, rsp_keycode_in;
   logic              rsp_empty_ff, rsp_empty_in;

   assign req_ready = !req_opcode || !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign byte_beat = accept && !req_opcode;
   assign pop_beat  = accept && req_opcode;

   ekdq_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .byte_beat (byte_beat),
      .in_byte   (req_in_byte),
      .push      (push)
   );

   assign ctrl.pop  = pop_beat;
   assign ctrl.push = push.valid;
   assign ctrl.code = push.code;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic                     prev_valid;
      ekdq_pkg::cell_state_type next_cell;

      if (i == 0) begin : g_head
         assign prev_valid = 1'b1;
      end else begin : g_body
         assign prev_valid = cells[i-1].valid;
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign next_cell = '0;
      end else begin : g_inner
         assign next_cell = cells[i+1];
      end

      ekdq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .prev_valid (prev_valid),
         .next_cell  (next_cell),
         .contents   (cells[i])
      );
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_keycode_in = rsp_keycode_ff;
      rsp_empty_in   = rsp_empty_ff;
      if (pop_beat) begin
         rsp_valid_in   = 1'b1;
         rsp_keycode_in = cells[0].valid ? cells[0].code : ekdq_pkg::KeyUnknown;
         rsp_empty_in   = !cells[0].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_keycode_ff <= rsp_keycode_in;
      rsp_empty_ff   <= rsp_empty_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_keycode         = rsp_keycode_ff;
   assign rsp_queue_was_empty = rsp_empty_ff;

endmodule

// File: sim/ekdq_test_pkg.sv
package ekdq_test_pkg;

   typedef enum logic {
      OpByte = 1'b0,
      OpPop  = 1'b1
   } op_type;

endpackage

// File: sim/escape_key_decoder_queue_checker.sv
module escape_key_decoder_queue_checker
   import ekdq_pkg::*;
   import ekdq_test_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     req_ready,
   input  logic     req_opcode,
   input  char_type req_in_byte,
   input  logic     rsp_valid,
   input  logic     rsp_ready,
   input  key_type  rsp_keycode,
   input  logic     rsp_queue_was_empty,
   output int       failures,
   output int       awaited
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [1:0] {
      PhaseIdle,
      PhaseLead,
      PhaseBody,
      PhaseDigit
   } phase_type;

   typedef struct packed {
      key_type code;
      logic    was_empty;
   } pop_result_type;

   key_type        held_keys[$];
   pop_result_type due_pops[$];
   phase_type      phase;
   logic           lead_bracket;
   char_type       held_digit;
   int             errors;
   pop_result_type want;
   key_type        k;

   function automatic void store_key(input key_type code);
      if (held_keys.size() < QueueDepth) held_keys.push_back(code);
   endfunction

   task automatic decode_char(input char_type b);
      case (phase)
         PhaseIdle: begin
            if (b == CharEsc) phase = PhaseLead;
            else store_key(key_type'(b));
         end
         PhaseLead: begin
            lead_bracket = (b == CharLBracket);
            phase = PhaseBody;
         end
         PhaseBody: begin
            if (!lead_bracket) begin
               store_key(KeyEsc);
               phase = PhaseIdle;
            end else if (b >= CharZero && b <= CharNine) begin
               held_digit = b;
               phase = PhaseDigit;
            end else begin
               case (b)
                  CharA:   k = KeyUp;
                  CharB:   k = KeyDown;
                  CharC:   k = KeyRight;
                  CharD:   k = KeyLeft;
                  CharH:   k = KeyHome;
                  CharF:   k = KeyEnd;
                  default: k = KeyUnknown;
               endcase
               store_key(k);
               phase = PhaseIdle;
            end
         end
         default: begin
            k = KeyUnknown;
            if (b == CharTilde) begin
               case (held_digit)
                  CharThree: k = KeyDelete;
                  CharFive:  k = KeyPgUp;
                  CharSix:   k = KeyPgDn;
                  default:   k = KeyUnknown;
               endcase
            end
            store_key(k);
            phase = PhaseIdle;
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         held_keys.delete();
         due_pops.delete();
         phase = PhaseIdle;
         lead_bracket = 1'b0;
         held_digit = '0;
         errors = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_pops.size() == 0) begin
               errors++;
               $display("%0t: unexpected rsp beat keycode=%0d empty=%0b",
                        $time, rsp_keycode, rsp_queue_was_empty);
            end else begin
               want = due_pops.pop_front();
               if (rsp_keycode !== want.code) begin
                  errors++;
                  $display("%0t: keycode expected %0d actual %0d",
                           $time, want.code, rsp_keycode);
               end
               if (rsp_queue_was_empty !== want.was_empty) begin
                  errors++;
                  $display("%0t: queue_was_empty expected %0b actual %0b",
                           $time, want.was_empty, rsp_queue_was_empty);
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_opcode == OpPop) begin
               if (held_keys.size() == 0) begin
                  due_pops.push_back('{KeyUnknown, 1'b1});
               end else begin
                  k = held_keys.pop_front();
                  due_pops.push_back('{k, 1'b0});
               end
            end else begin
               decode_char(req_in_byte);
            end
         end
      end
      failures <= errors;
      awaited  <= due_pops.size();
   end

endmodule

// File: sim/escape_key_decoder_queue_top_test.sv
module escape_key_decoder_queue_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import ekdq_pkg::*;
   import ekdq_test_pkg::*;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_ready;
   logic     req_opcode = OpByte;
   char_type req_in_byte = '0;
   logic     rsp_valid;
   logic     rsp_ready = 1'b0;
   key_type  rsp_keycode;
   logic     rsp_queue_was_empty;
   int       failures;
   int       awaited;
   int       beats = 0;
   int       send_calm = 0;
   int       take_calm = 0;

   escape_key_decoder_queue_top uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_opcode(req_opcode),
      .req_in_byte(req_in_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_keycode(rsp_keycode),
      .rsp_queue_was_empty(rsp_queue_was_empty)
   );

   escape_key_decoder_queue_checker scoreboard (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_opcode(req_opcode),
      .req_in_byte(req_in_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_keycode(rsp_keycode),
      .rsp_queue_was_empty(rsp_queue_was_empty),
      .failures(failures),
      .awaited(awaited)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // occasional stretches with no idling
   function automatic int draw_gap(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) calm = $urandom_range(5, 30);
      return $urandom_range(0, 14);
   endfunction

   initial begin
      int gap;
      forever begin
         gap = draw_gap(take_calm);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   task automatic send_beat(input op_type op, input char_type b);
      int gap;
      gap = draw_gap(send_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_opcode  <= op;
      req_in_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      beats++;
   endtask

   task automatic put_char(input char_type b);
      send_beat(OpByte, b);
   endtask

   task automatic pop_key();
      send_beat(OpPop, char_type'($urandom_range(0, 255)));
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited != 0) @(posedge clock);
   endtask

   task automatic send_sequence();
      char_type letters[6];
      char_type digits[3];
      int       kind;
      int       n;
      letters = '{CharA, CharB, CharC, CharD, CharH, CharF};
      digits  = '{CharThree, CharFive, CharSix};
      kind = $urandom_range(0, 9);
      if (kind <= 2) begin
         put_char(char_type'($urandom_range(0, 255)));
      end else if (kind <= 4) begin
         put_char(CharEsc);
         put_char(CharLBracket);
         if ($urandom_range(0, 6) == 0) put_char(char_type'($urandom_range(0, 255)));
         else put_char(letters[$urandom_range(0, 5)]);
      end else if (kind <= 6) begin
         put_char(CharEsc);
         put_char(CharLBracket);
         if ($urandom_range(0, 2) == 0) put_char(CharZero + char_type'($urandom_range(0, 9)));
         else put_char(digits[$urandom_range(0, 2)]);
         if ($urandom_range(0, 4) == 0) put_char(char_type'($urandom_range(0, 255)));
         else put_char(CharTilde);
      end else if (kind == 7) begin
         put_char(CharEsc);
         put_char(char_type'($urandom_range(0, 255)));
         put_char(char_type'($urandom_range(0, 255)));
      end else if (kind == 8) begin
         n = $urandom_range(1, 3);
         repeat (n) put_char(char_type'($urandom_range(0, 255)));
      end else begin
         put_char(CharEsc);
         put_char(CharLBracket);
         put_char(char_type'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      int mode;
      int n;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // empty queue, byte extremes
      pop_key();
      put_char(8'h00);
      put_char(8'hFF);
      put_char(CharEsc);
      put_char(CharLBracket);
      put_char(CharA);
      // ESC taken as a sequence byte, no bracket gives esc key
      put_char(CharEsc);
      put_char(8'h78);
      put_char(CharEsc);
      put_char(CharEsc);
      put_char(CharLBracket);
      put_char(CharThree);
      put_char(CharTilde);
      // pop in the middle of a sequence
      put_char(CharEsc);
      put_char(CharLBracket);
      put_char(CharFive);
      pop_key();
      put_char(CharTilde);
      put_char(CharEsc);
      put_char(CharLBracket);
      put_char(CharSix);
      put_char(8'h78);
      pop_key();
      pop_key();
      pop_key();
      settle();

      while (beats < 450) begin
         mode = $urandom_range(0, 9);
         if (mode == 0) begin
            // overfill the queue, then drain it to empty or past empty
            n = $urandom_range(17, 22);
            repeat (n) send_sequence();
            n = $urandom_range(16, 20);
            repeat (n) pop_key();
         end else if (mode == 1) begin
            settle();
            n = $urandom_range(1, 4);
            repeat (n) pop_key();
         end else begin
            n = $urandom_range(1, 8);
            repeat (n) begin
               if ($urandom_range(0, 2) == 0) pop_key();
               else send_sequence();
            end
         end
      end

      settle();
      repeat (10) @(posedge clock);
      if (failures == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #500_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// File: files.f
rtl/core/ekdq_pkg.sv
rtl/core/ekdq_parser.sv
rtl/core/ekdq_cell.sv
rtl/core/escape_key_decoder_queue_top.sv
sim/ekdq_test_pkg.sv
sim/escape_key_decoder_queue_checker.sv
sim/escape_key_decoder_queue_top_test.sv
